// ===== hw/rtl/dft32_pkg.sv =====
// shared types, constants and twiddle table for the 32 point half spectrum dft
package dft32_pkg;

    localparam int DEF_POINTS  = 32;
    localparam int DEF_BINS    = 16;

    localparam int SAMPLE_W    = 11;
    localparam int TW_W        = 16;
    localparam int PROD_W      = SAMPLE_W + TW_W;
    localparam int OUT_W       = 24;
    localparam int BIN_W       = 4;
    localparam int TW_ENTRIES  = 32;
    localparam int TW_IDX_W    = 5;
    localparam int SIN_OFFSET  = 24;
    localparam int ROUND_SHIFT = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 56;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } dft32_state_t;

    // q1.15 cosine, +1.0 held as 32767
    function automatic logic signed [TW_W-1:0] cos_q15(input logic [TW_IDX_W-1:0] idx);
        logic signed [TW_W-1:0] c;
        case (idx)
            5'd0:  c = 16'sd32767;
            5'd1:  c = 16'sd32138;
            5'd2:  c = 16'sd30274;
            5'd3:  c = 16'sd27246;
            5'd4:  c = 16'sd23170;
            5'd5:  c = 16'sd18205;
            5'd6:  c = 16'sd12540;
            5'd7:  c = 16'sd6393;
            5'd8:  c = 16'sd0;
            5'd9:  c = -16'sd6393;
            5'd10: c = -16'sd12540;
            5'd11: c = -16'sd18205;
            5'd12: c = -16'sd23170;
            5'd13: c = -16'sd27246;
            5'd14: c = -16'sd30274;
            5'd15: c = -16'sd32138;
            5'd16: c = -16'sd32767;
            5'd17: c = -16'sd32138;
            5'd18: c = -16'sd30274;
            5'd19: c = -16'sd27246;
            5'd20: c = -16'sd23170;
            5'd21: c = -16'sd18205;
            5'd22: c = -16'sd12540;
            5'd23: c = -16'sd6393;
            5'd24: c = 16'sd0;
            5'd25: c = 16'sd6393;
            5'd26: c = 16'sd12540;
            5'd27: c = 16'sd18205;
            5'd28: c = 16'sd23170;
            5'd29: c = 16'sd27246;
            5'd30: c = 16'sd30274;
            5'd31: c = 16'sd32138;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/dft_32_point_half_spectrum.sv =====
// direct dft over frames of POINTS samples, first BINS bins, one shared mac pair
// after the last sample of a frame, bin 0 is computed, then each further bin in turn,
//   with one pass of the shared real/imag mac pair per bin
// input: POINTS samples are taken one per cycle, then the input is held off until the
//   last bin is loaded into the result register, so output stalls hold it off as well
// reset: aresetn low at a rising edge empties the frame, the pipeline and the result register
module dft_32_point_half_spectrum #(
    parameter int POINTS = dft32_pkg::DEF_POINTS,
    parameter int BINS   = dft32_pkg::DEF_BINS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dft32_pkg::S_TDATA_W-1:0]  s_tdata,   // [10:0] sample, rest zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dft32_pkg::M_TDATA_W-1:0]  m_tdata,   // [3:0] bin_index, [27:4] real_part,
                                                        // [51:28] imag_part, rest zero
    output logic                             m_tlast    // last_bin
);

    localparam int PH_W   = $clog2(POINTS);
    localparam int K_W    = (BINS > 1) ? $clog2(BINS) : 1;
    // product is 26 bits of magnitude plus sign, grown by the number of terms
    localparam int ACC_RAW = dft32_pkg::PROD_W + $clog2(POINTS);
    localparam int ACC_MIN = dft32_pkg::OUT_W + dft32_pkg::ROUND_SHIFT + 1;
    localparam int ACC_W  = (ACC_RAW > ACC_MIN) ? ACC_RAW : ACC_MIN;
    localparam int RND_W  = ACC_W - dft32_pkg::ROUND_SHIFT;
    localparam int PAD_W  = dft32_pkg::M_TDATA_W - dft32_pkg::BIN_W - 2 * dft32_pkg::OUT_W;

    dft32_pkg::dft32_state_t state_reg, state_next;

    // frame store
    logic [dft32_pkg::SAMPLE_W-1:0] mem [POINTS];

    logic [PH_W-1:0] count_reg;
    logic [PH_W-1:0] n_reg;
    logic [PH_W-1:0] phase_reg;
    logic [PH_W-1:0] phase_next;
    logic [PH_W-1:0] step_reg;
    logic [PH_W:0]   phase_sum;
    logic [K_W-1:0]  k_reg;

    // twiddle index for each phase, floor(phase*32/POINTS)
    logic [dft32_pkg::TW_IDX_W-1:0] tw_lut [POINTS];
    logic [dft32_pkg::TW_IDX_W-1:0] tw_idx;
    logic [dft32_pkg::TW_IDX_W-1:0] sin_idx;

    // mac pipeline: read/twiddle stage, product stage, accumulate
    logic                                  v1_reg, v2_reg;
    logic signed [dft32_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [dft32_pkg::TW_W-1:0]     cos_reg, sin_reg;
    logic signed [dft32_pkg::PROD_W-1:0]   prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]               acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]               bias_re, bias_im;

    // result register
    logic                           m_tvalid_reg;
    logic [dft32_pkg::BIN_W-1:0]    bin_reg;
    logic [dft32_pkg::OUT_W-1:0]    re_out_reg, im_out_reg;
    logic                           last_reg;

    // sequencer strobes
    logic s_accept;
    logic frame_done;
    logic issue;
    logic out_load;
    logic last_k;
    logic acc_clr;

    genvar p;
    generate
        for (p = 0; p < POINTS; p++) begin : g_tw_lut
            localparam int unsigned TW_IDX = (p * dft32_pkg::TW_ENTRIES) / POINTS;
            assign tw_lut[p] = dft32_pkg::TW_IDX_W'(TW_IDX);
        end
    endgenerate

    function automatic logic [dft32_pkg::OUT_W-1:0] sat_out(input logic [RND_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        logic [dft32_pkg::OUT_W-1:0] r;
        hi_ones  = &v[RND_W-1:dft32_pkg::OUT_W-1];
        hi_zeros = ~|v[RND_W-1:dft32_pkg::OUT_W-1];
        if (hi_ones || hi_zeros) begin
            r = v[dft32_pkg::OUT_W-1:0];
        end else if (v[RND_W-1]) begin
            r = {1'b1, {(dft32_pkg::OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(dft32_pkg::OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign tw_idx    = tw_lut[phase_reg];
    assign sin_idx   = tw_idx + dft32_pkg::TW_IDX_W'(dft32_pkg::SIN_OFFSET);
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};
    assign phase_next = (phase_sum >= (PH_W + 1)'(POINTS)) ?
                        PH_W'(phase_sum - (PH_W + 1)'(POINTS)) : PH_W'(phase_sum);
    assign last_k    = (k_reg == K_W'(BINS - 1));
    assign s_accept  = s_tvalid && s_tready;
    assign frame_done = s_accept && (count_reg == PH_W'(POINTS - 1));

    // +64 then floor shift by 7
    assign bias_re = acc_re_reg + ACC_W'(64);
    assign bias_im = acc_im_reg + ACC_W'(64);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dft32_pkg::ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        acc_clr    = 1'b0;
        case (state_reg)
            dft32_pkg::ST_COLLECT: begin
                s_tready = 1'b1;
                if (frame_done) begin
                    acc_clr    = 1'b1;
                    state_next = dft32_pkg::ST_MAC;
                end
            end
            dft32_pkg::ST_MAC: begin
                issue = 1'b1;
                if (n_reg == PH_W'(POINTS - 1)) begin
                    state_next = dft32_pkg::ST_DRAIN;
                end
            end
            dft32_pkg::ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = dft32_pkg::ST_EMIT;
                end
            end
            dft32_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    acc_clr  = 1'b1;
                    if (last_k) begin
                        state_next = dft32_pkg::ST_COLLECT;
                    end else begin
                        state_next = dft32_pkg::ST_MAC;
                    end
                end
            end
            default: begin
                state_next = dft32_pkg::ST_COLLECT;
            end
        endcase
    end

    // frame store write and registered read
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem[count_reg] <= s_tdata[dft32_pkg::SAMPLE_W-1:0];
        end
        x_reg <= mem[n_reg];
    end

    // sample counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (frame_done) begin
            count_reg <= '0;
        end else if (s_accept) begin
            count_reg <= count_reg + PH_W'(1);
        end
    end

    // bin and phase sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= '0;
            phase_reg <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
        end else if (frame_done) begin
            n_reg     <= '0;
            phase_reg <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
        end else if (issue) begin
            n_reg     <= (n_reg == PH_W'(POINTS - 1)) ? '0 : n_reg + PH_W'(1);
            phase_reg <= (n_reg == PH_W'(POINTS - 1)) ? '0 : phase_next;
        end else if (out_load && !last_k) begin
            k_reg    <= k_reg + K_W'(1);
            // step is k mod POINTS
            step_reg <= (step_reg == PH_W'(POINTS - 1)) ? '0 : step_reg + PH_W'(1);
        end
    end

    // twiddle fetch, products, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cos_reg     <= dft32_pkg::cos_q15(tw_idx);
        sin_reg     <= dft32_pkg::cos_q15(sin_idx);
        prod_re_reg <= dft32_pkg::PROD_W'(x_reg) * dft32_pkg::PROD_W'(cos_reg);
        prod_im_reg <= dft32_pkg::PROD_W'(x_reg) * dft32_pkg::PROD_W'(sin_reg);
        if (acc_clr) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (v2_reg) begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(prod_im_reg);
        end
    end

    // result register, rounded and saturated on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            bin_reg    <= dft32_pkg::BIN_W'(k_reg);
            re_out_reg <= sat_out(bias_re[ACC_W-1:dft32_pkg::ROUND_SHIFT]);
            im_out_reg <= sat_out(bias_im[ACC_W-1:dft32_pkg::ROUND_SHIFT]);
            last_reg   <= last_k;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, im_out_reg, re_out_reg, bin_reg};
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // no sample taken while the mac pipeline holds work
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!v1_reg && !v2_reg))
        else $error("input ready while mac pipeline busy");

    // work enters the pipeline only from the mac state
    a_issue_src: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> $past(state_reg == dft32_pkg::ST_MAC))
        else $error("mac pipeline loaded outside mac state");

    // product stage always follows a fetch
    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> $past(v1_reg))
        else $error("product stage valid without fetch");

    // final bin returns to an empty frame
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_k) |=> (state_reg == dft32_pkg::ST_COLLECT && count_reg == '0))
        else $error("frame not restarted after last bin");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");
`endif

endmodule

// ===== test/dft_32_point_half_spectrum_tb.sv =====
// self-checking testbench for the 32 point half spectrum dft: random frames, bin-by-bin compare
module dft_32_point_half_spectrum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS     = dft32_pkg::DEF_POINTS;
    localparam int BINS       = dft32_pkg::DEF_BINS;
    localparam int RAND_FRAMES = 3;
    localparam int QUIET_LIMIT = 3000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES = 400;    // long receiver stall, past one frame of input and a bin
    localparam int DRAIN_WAIT  = 60;     // above bin 0 latency

    // how a random frame is filled
    typedef enum int {
        FILL_UNIFORM,
        FILL_EXTREME,
        FILL_SMALL,
        FILL_FLAT
    } frame_fill_t;

    typedef struct {
        logic [dft32_pkg::BIN_W-1:0]        bin;
        logic signed [dft32_pkg::OUT_W-1:0] re;
        logic signed [dft32_pkg::OUT_W-1:0] im;
        logic                               last;
    } bin_result_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [dft32_pkg::S_TDATA_W-1:0]  s_tdata  = '0;     // [10:0] sample, rest zero
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dft32_pkg::M_TDATA_W-1:0]  m_tdata;           // [3:0] bin_index, [27:4] real_part,
                                                         // [51:28] imag_part, rest zero
    logic                             m_tlast;           // last_bin

    // q1.15 cosine, one full turn in 32 steps, +1.0 clipped to 32767
    int twiddle_cos [32] = '{
        32767, 32138, 30274, 27246, 23170, 18205, 12540, 6393,
        0, -6393, -12540, -18205, -23170, -27246, -30274, -32138,
        -32767, -32138, -30274, -27246, -23170, -18205, -12540, -6393,
        0, 6393, 12540, 18205, 23170, 27246, 30274, 32138
    };

    logic [dft32_pkg::SAMPLE_W-1:0] sample_feed [$];      // samples not yet handed to the driver
    bin_result_t                    bins_due [$];         // predicted bins, oldest first
    logic [dft32_pkg::SAMPLE_W-1:0] frame_buf [POINTS];   // predictor copy of the sample store
    int                             frame_fill = 0;

    int samples_taken = 0;
    int bins_checked  = 0;
    int frames_done   = 0;
    int errors        = 0;
    int tx_idle_pct   = 25;
    int rx_idle_pct   = 70;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int quiet         = 0;

    dft_32_point_half_spectrum dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    // round the q.15 sum to 8 fraction bits (floor after adding half) and clamp to 24 bits
    function automatic logic signed [dft32_pkg::OUT_W-1:0] scale_to_q8(longint acc);
        longint r;
        r = (acc + 64) >>> dft32_pkg::ROUND_SHIFT;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        if (r < -64'sd8388608)
            r = -64'sd8388608;
        return r[dft32_pkg::OUT_W-1:0];
    endfunction

    // direct dft of the held frame, bins 0 to BINS-1, queued in emit order
    function automatic void predict_spectrum();
        bin_result_t b;
        longint      acc_re;
        longint      acc_im;
        longint      x;
        int          phase;
        for (int k = 0; k < BINS; k++) begin
            acc_re = 0;
            acc_im = 0;
            for (int n = 0; n < POINTS; n++) begin
                x      = longint'($signed(frame_buf[n]));
                phase  = (n * k) % POINTS;
                acc_re += x * twiddle_cos[phase];
                // sin(a) read as cos(a - quarter turn)
                acc_im -= x * twiddle_cos[(phase + 24) % 32];
            end
            b.bin  = k[dft32_pkg::BIN_W-1:0];
            b.re   = scale_to_q8(acc_re);
            b.im   = scale_to_q8(acc_im);
            b.last = (k == BINS - 1);
            bins_due.push_back(b);
        end
    endfunction

    // store one accepted sample; a full frame yields a spectrum and starts over
    function automatic void absorb_sample(logic [dft32_pkg::SAMPLE_W-1:0] s);
        frame_buf[frame_fill] = s;
        frame_fill++;
        if (frame_fill == POINTS) begin
            frame_fill = 0;
            frames_done++;
            predict_spectrum();
        end
    endfunction

    function automatic logic [dft32_pkg::SAMPLE_W-1:0] draw_sample(
            frame_fill_t fill, logic [dft32_pkg::SAMPLE_W-1:0] level);
        logic [dft32_pkg::SAMPLE_W-1:0] s;
        case (fill)
            FILL_UNIFORM: s = dft32_pkg::SAMPLE_W'($urandom_range(0, 2047));
            FILL_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       s = 11'h400;   // most negative
                    1:       s = 11'h3FF;   // most positive
                    2:       s = 11'h000;
                    default: s = 11'h7FF;   // minus one
                endcase
            end
            FILL_SMALL: s = dft32_pkg::SAMPLE_W'($urandom_range(0, 15) - 8);
            default:    s = level;
        endcase
        return s;
    endfunction

    // sender: new item only once the previous one is gone, random gaps per phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                absorb_sample(s_tdata[dft32_pkg::SAMPLE_W-1:0]);
                samples_taken++;
            end
            // sender idles a lot in the second phase, then stops idling
            if (samples_taken >= 86)
                tx_idle_pct = 0;
            else if (samples_taken >= 43)
                tx_idle_pct = 70;
            if (sample_feed.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(dft32_pkg::S_TDATA_W-dft32_pkg::SAMPLE_W){1'b0}},
                             sample_feed.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: compare every bin against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (bins_due.size() == 0) begin
                    $error("bin %0d arrived with no result pending", m_tdata[3:0]);
                    errors++;
                end else begin
                    bin_result_t want;
                    want = bins_due.pop_front();
                    if (m_tdata[3:0] !== want.bin) begin
                        $error("bin_index: expected %0d, got %0d", want.bin, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[27:4] !== want.re) begin
                        $error("real_part: expected %0d, got %0d",
                               want.re, $signed(m_tdata[27:4]));
                        errors++;
                    end
                    if (m_tdata[51:28] !== want.im) begin
                        $error("imag_part: expected %0d, got %0d",
                               want.im, $signed(m_tdata[51:28]));
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_bin: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
                bins_checked++;
            end
            // receiver stalls hard first, then lightly, then never
            if (bins_checked >= 42)
                rx_idle_pct = 0;
            else if (bins_checked >= 21)
                rx_idle_pct = 25;
            // once the first spectrum is out, block the output long enough for the
            // next frame to come in and back up behind it
            if (!hold_done && bins_checked >= BINS) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("stalled: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        frame_fill_t                    fill;
        logic [dft32_pkg::SAMPLE_W-1:0] level;
        int                             total_samples;

        // directed frame: both extremes, zero, plus and minus one, alternating bit
        // patterns, then a full-scale square wave
        sample_feed.push_back(11'h400);
        sample_feed.push_back(11'h3FF);
        sample_feed.push_back(11'h000);
        sample_feed.push_back(11'h7FF);
        sample_feed.push_back(11'h001);
        sample_feed.push_back(11'h555);
        sample_feed.push_back(11'h2AA);
        for (int n = 7; n < POINTS; n++)
            sample_feed.push_back((n % 2) ? 11'h3FF : 11'h400);

        // random frames: the first uniform over the full range, the rest mixed
        for (int f = 0; f < RAND_FRAMES; f++) begin
            fill  = (f == 0) ? FILL_UNIFORM : frame_fill_t'($urandom_range(0, 3));
            level = dft32_pkg::SAMPLE_W'($urandom_range(0, 2047));
            for (int n = 0; n < POINTS; n++)
                sample_feed.push_back(draw_sample(fill, level));
        end
        total_samples = sample_feed.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // all samples in, every predicted bin seen, then a short quiet tail
        while (samples_taken < total_samples || bins_due.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d samples in %0d frames, %0d bins compared", samples_taken, frames_done,
                 bins_checked);
        $display("traffic: gaps on both sides, one %0d-cycle output stall, no-gap tail",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
